/* rtl/mcpipe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcpipe_pkg
// Shared types and codes for the multi-channel byte pipe table: beat layouts
// of the request and response channels, operation and status codes, and the
// control bundles passed between the top level and the operation decoder.
// ----------------------------------------------------------------------------
package mcpipe_pkg;

    // Width of the per-pipe reader and writer reference counts.
    localparam int REF_W = 8;
    localparam logic [REF_W-1:0] REF_MAX = '1;

    typedef enum logic [2:0] {
        OP_ALLOC = 3'd0,
        OP_WRITE = 3'd1,
        OP_READ  = 3'd2,
        OP_REF   = 3'd3,
        OP_CLOSE = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BAD    = 3'd1,
        ST_BLOCK  = 3'd2,
        ST_EOF    = 3'd3,
        ST_EPIPE  = 3'd4,
        ST_NOFREE = 3'd5
    } status_t;

    // One request beat.
    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] pipe_index;
        logic       write_end;
        logic [7:0] data_in;
        logic       last_byte;
    } req_beat_t;

    // One response beat.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_out;
        logic [2:0] new_pipe;
        logic       readable;
        logic       writable;
        logic       last_flag;
    } rsp_beat_t;

    // Condensed view of the addressed pipe's descriptor.
    typedef struct packed {
        logic live;
        logic rref_zero;
        logic wref_zero;
        logic rref_max;
        logic wref_max;
        logic empty;
        logic full;
    } pipe_view_t;

    // Decision taken for one operation.
    typedef struct packed {
        status_t status;
        logic    alloc;
        logic    ring_wr;
        logic    ring_rd;
        logic    ref_inc;
        logic    ref_dec;
        logic    ref_writer;
    } exec_ctrl_t;

endpackage
`default_nettype wire

/* rtl/mcpipe_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcpipe_req_if / mcpipe_rsp_if
// Valid/ready channels of the pipe table. A beat moves at a rising clock
// edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface mcpipe_req_if
    import mcpipe_pkg::*;
();
    logic      valid;
    logic      ready;
    req_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mcpipe_rsp_if
    import mcpipe_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/mcpipe_exec.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcpipe_exec
// Operation decoder: finds the lowest free pipe and decides, from the
// addressed pipe's descriptor view, the status and which updates to apply.
// ----------------------------------------------------------------------------
module mcpipe_exec
    import mcpipe_pkg::*;
#(
    parameter int PIPE_COUNT = 8,
    localparam int PIPE_W = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1
) (
    input  wire logic [2:0]            opcode,
    input  wire logic                  write_end,
    input  wire pipe_view_t            view,
    input  wire logic [PIPE_COUNT-1:0] live,
    output exec_ctrl_t                 ctrl,
    output logic [PIPE_W-1:0]          free_idx
);

    logic free_found;

    // Lowest-numbered pipe with no live references.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = PIPE_COUNT - 1; i >= 0; i--)
        begin
            if (!live[i])
            begin
                free_found = 1'b1;
                free_idx   = PIPE_W'(i);
            end
        end
    end

    // Status and update decision per operation.
    always_comb
    begin
        ctrl            = '0;
        ctrl.status     = ST_OK;
        ctrl.ref_writer = write_end;
        unique case (opcode)
            OP_ALLOC:
            begin
                if (free_found)
                    ctrl.alloc = 1'b1;
                else
                    ctrl.status = ST_NOFREE;
            end
            OP_WRITE:
            begin
                if (!view.live || view.wref_zero)
                    ctrl.status = ST_BAD;
                else if (view.rref_zero)
                    ctrl.status = ST_EPIPE;
                else if (view.full)
                    ctrl.status = ST_BLOCK;
                else
                    ctrl.ring_wr = 1'b1;
            end
            OP_READ:
            begin
                if (!view.live || view.rref_zero)
                    ctrl.status = ST_BAD;
                else if (!view.empty)
                    ctrl.ring_rd = 1'b1;
                else if (view.wref_zero)
                    ctrl.status = ST_EOF;
                else
                    ctrl.status = ST_BLOCK;
            end
            OP_REF:
            begin
                if (!view.live)
                    ctrl.status = ST_BAD;
                else if (write_end ? !view.wref_max : !view.rref_max)
                    ctrl.ref_inc = 1'b1;
            end
            OP_CLOSE:
            begin
                if (!view.live)
                    ctrl.status = ST_BAD;
                else if (write_end ? !view.wref_zero : !view.rref_zero)
                    ctrl.ref_dec = 1'b1;
            end
            default:
                ctrl.status = ST_BAD;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/multi_channel_refcounted_pipe_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_refcounted_pipe_fifo
// Table of reference-counted byte pipes, each with its own ring buffer.
//
// Requests arrive on req (allocate, write byte, read byte, add reference,
// close end); exactly one response beat leaves on rsp for every request.
// Each pipe's pointers, fill count and reference counts live in a descriptor
// memory; the bytes live in a shared ring memory of PIPE_COUNT x
// BUFFER_BYTES entries. Both memories have one port with registered reads.
//
// Sequencing: an idle block takes a request, and its descriptor read
// comes back the next cycle, where the response is decided and the
// descriptor is written back. Allocate, write, reference and close pass
// through the idle and lookup states; a successful read also passes the
// data state, as the ring read needs the descriptor's read pointer. A new
// request is taken while an earlier response sits in the output register.
//
// Reset clears all live flags, so every pipe is free; the memories need no
// clearing pass. When the receiver stalls, the finished response holds in
// the output register. The next operation waits to commit, except a
// successful read, which commits, then holds its byte until the slot frees.
// ----------------------------------------------------------------------------
module multi_channel_refcounted_pipe_fifo
    import mcpipe_pkg::*;
#(
    parameter int PIPE_COUNT   = 8,
    parameter int BUFFER_BYTES = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mcpipe_req_if.sink         req,
    mcpipe_rsp_if.source       rsp
);

    localparam int PIPE_W     = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int BUF_W      = $clog2(BUFFER_BYTES);
    localparam int FILL_W     = $clog2(BUFFER_BYTES + 1);
    localparam int RING_DEPTH = PIPE_COUNT * BUFFER_BYTES;
    localparam int RING_W     = $clog2(RING_DEPTH);

    localparam logic [BUF_W-1:0]  PTR_LAST  = BUF_W'(BUFFER_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_BYTES);

    typedef struct packed {
        logic [BUF_W-1:0]  rd_ptr;
        logic [BUF_W-1:0]  wr_ptr;
        logic [FILL_W-1:0] fill;
        logic [REF_W-1:0]  rrefs;
        logic [REF_W-1:0]  wrefs;
    } desc_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DATA
    } state_t;

    state_t                  state_reg;
    logic [PIPE_COUNT-1:0]   live_reg;
    logic [PIPE_COUNT-1:0]   live_next;
    logic                    out_valid_reg;
    rsp_beat_t               out_payload_reg;
    rsp_beat_t               pend_reg;
    rsp_beat_t               res_next;

    logic [2:0]              op_reg;
    logic                    wend_reg;
    logic [7:0]              din_reg;
    logic                    last_reg;
    logic                    idx_ok_reg;
    logic [PIPE_W-1:0]       pipe_sel_reg;

    desc_t                   desc_mem [PIPE_COUNT];
    desc_t                   desc_q_reg;
    desc_t                   desc_next;
    logic [7:0]              ring_mem [RING_DEPTH];
    logic [7:0]              ring_q_reg;

    logic                    req_fire;
    logic                    req_idx_ok;
    logic [PIPE_W-1:0]       req_sel;
    logic                    out_free;
    logic                    out_load;
    logic                    commit;
    logic                    desc_we;
    logic [PIPE_W-1:0]       tgt_idx;
    logic [PIPE_W-1:0]       free_idx;
    pipe_view_t              view;
    exec_ctrl_t              ctrl;
    logic                    flag_live;
    logic [BUF_W-1:0]        ring_ptr;
    logic [RING_W-1:0]       ring_addr;
    logic                    ring_we;
    logic                    ring_re;

    // Request side handshake and index check.
    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign req_idx_ok = (32'(req.payload.pipe_index) < PIPE_COUNT);
    assign req_sel    = req_idx_ok ? PIPE_W'(req.payload.pipe_index) : '0;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_payload_reg;
    assign out_free    = !out_valid_reg || rsp.ready;

    // Descriptor view of the addressed pipe.
    always_comb
    begin
        view.live      = idx_ok_reg && live_reg[pipe_sel_reg];
        view.rref_zero = (desc_q_reg.rrefs == '0);
        view.wref_zero = (desc_q_reg.wrefs == '0);
        view.rref_max  = (desc_q_reg.rrefs == REF_MAX);
        view.wref_max  = (desc_q_reg.wrefs == REF_MAX);
        view.empty     = (desc_q_reg.fill == '0);
        view.full      = (desc_q_reg.fill == FILL_FULL);
    end

    mcpipe_exec #(
        .PIPE_COUNT (PIPE_COUNT)
    ) u_exec (
        .opcode    (op_reg),
        .write_end (wend_reg),
        .view      (view),
        .live      (live_reg),
        .ctrl      (ctrl),
        .free_idx  (free_idx)
    );

    // A successful read commits at once; every other operation waits for the output slot.
    assign commit  = (state_reg == S_LOOK) && (ctrl.ring_rd || out_free);
    assign desc_we = commit && (ctrl.alloc || ctrl.ring_wr || ctrl.ring_rd ||
                                ctrl.ref_inc || ctrl.ref_dec);
    assign tgt_idx = ctrl.alloc ? free_idx : pipe_sel_reg;

    // A response enters the output register straight from lookup, or from
    // the data phase once the ring byte is back.
    assign out_load = (commit && !ctrl.ring_rd) || ((state_reg == S_DATA) && out_free);

    // Updated descriptor.
    always_comb
    begin
        desc_next = desc_q_reg;
        if (ctrl.alloc)
        begin
            desc_next       = '0;
            desc_next.rrefs = REF_W'(1);
            desc_next.wrefs = REF_W'(1);
        end
        else if (ctrl.ring_wr)
        begin
            desc_next.wr_ptr = (desc_q_reg.wr_ptr == PTR_LAST) ? '0 : desc_q_reg.wr_ptr + 1'b1;
            desc_next.fill   = desc_q_reg.fill + 1'b1;
        end
        else if (ctrl.ring_rd)
        begin
            desc_next.rd_ptr = (desc_q_reg.rd_ptr == PTR_LAST) ? '0 : desc_q_reg.rd_ptr + 1'b1;
            desc_next.fill   = desc_q_reg.fill - 1'b1;
        end
        else if (ctrl.ref_inc)
        begin
            if (ctrl.ref_writer)
                desc_next.wrefs = desc_q_reg.wrefs + 1'b1;
            else
                desc_next.rrefs = desc_q_reg.rrefs + 1'b1;
        end
        else if (ctrl.ref_dec)
        begin
            if (ctrl.ref_writer)
                desc_next.wrefs = desc_q_reg.wrefs - 1'b1;
            else
                desc_next.rrefs = desc_q_reg.rrefs - 1'b1;
        end
    end

    // Live flags: set on allocate, dropped when both counts reach zero.
    always_comb
    begin
        live_next = live_reg;
        if (ctrl.alloc)
            live_next[free_idx] = 1'b1;
        else if (ctrl.ref_dec)
            live_next[pipe_sel_reg] = (desc_next.rrefs != '0) || (desc_next.wrefs != '0);
    end

    // Response fields, flags taken after the update.
    always_comb
    begin
        flag_live = ctrl.alloc ||
                    ((op_reg != OP_ALLOC) && view.live &&
                     ((desc_next.rrefs != '0) || (desc_next.wrefs != '0)));
        res_next.status    = ctrl.status;
        res_next.data_out  = '0;
        res_next.new_pipe  = ctrl.alloc ? 3'(free_idx) : 3'd0;
        res_next.readable  = flag_live &&
                             ((desc_next.fill != '0) || (desc_next.wrefs == '0));
        res_next.writable  = flag_live &&
                             ((desc_next.fill != FILL_FULL) || (desc_next.rrefs == '0));
        res_next.last_flag = last_reg;
    end

    // Ring memory address: pipe base plus the pointer in use.
    assign ring_ptr  = ctrl.ring_wr ? desc_q_reg.wr_ptr : desc_q_reg.rd_ptr;
    assign ring_addr = RING_W'(pipe_sel_reg) * RING_W'(BUFFER_BYTES) + RING_W'(ring_ptr);
    assign ring_we   = commit && ctrl.ring_wr;
    assign ring_re   = commit && ctrl.ring_rd;

    // Descriptor memory: read on request, written back on commit.
    always_ff @(posedge clk)
    begin
        if (desc_we)
            desc_mem[tgt_idx] <= desc_next;
        if (req_fire)
            desc_q_reg <= desc_mem[req_sel];
    end

    // Ring byte memory, one access per cycle.
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_addr] <= din_reg;
        if (ring_re)
            ring_q_reg <= ring_mem[ring_addr];
    end

    // Sequencer, live flags and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            live_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_payload_reg <= '0;
            pend_reg        <= '0;
            op_reg          <= '0;
            wend_reg        <= 1'b0;
            din_reg         <= '0;
            last_reg        <= 1'b0;
            idx_ok_reg      <= 1'b0;
            pipe_sel_reg    <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg       <= req.payload.opcode;
                        wend_reg     <= req.payload.write_end;
                        din_reg      <= req.payload.data_in;
                        last_reg     <= req.payload.last_byte;
                        idx_ok_reg   <= req_idx_ok;
                        pipe_sel_reg <= req_sel;
                        state_reg    <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (commit)
                    begin
                        live_reg <= live_next;
                        if (ctrl.ring_rd)
                        begin
                            pend_reg  <= res_next;
                            state_reg <= S_DATA;
                        end
                        else
                        begin
                            out_payload_reg <= res_next;
                            state_reg       <= S_IDLE;
                        end
                    end
                end
                S_DATA:
                begin
                    if (out_free)
                    begin
                        out_payload_reg <= {pend_reg.status, ring_q_reg, pend_reg.new_pipe,
                                            pend_reg.readable, pend_reg.writable,
                                            pend_reg.last_flag};
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // An allocation always lands on a pipe that is currently free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && ctrl.alloc) |-> !live_reg[free_idx])
        else $error("allocate picked a live pipe");

    // The data phase is only entered after a ring read was issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA && $past(state_reg) == S_LOOK) |-> $past(ring_re))
        else $error("data phase without ring read");

    // A written-back fill count never exceeds the buffer size.
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_we |-> (desc_next.fill <= FILL_FULL))
        else $error("fill count overflow");

endmodule
`default_nettype wire

/* verif/multi_channel_refcounted_pipe_fifo_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_refcounted_pipe_fifo_test
// Self-checking bench for the reference-counted byte pipe table. A driver
// sends request beats from a queue of planned operations. At each accepted
// request, a behavioral copy of the pipe table works out the response beat.
// A monitor compares every response beat field by field with the oldest
// prediction. Stimulus starts with a short directed list. It then runs
// random pipe sessions (allocate, write and read bursts, reference changes
// and releases), one flood to a full ring, one saturated reference count,
// and an exhaustion of the table. Back-pressure varies by phase, and one
// long receiver stall fills the block.
// ----------------------------------------------------------------------------
module multi_channel_refcounted_pipe_fifo_test;
    import mcpipe_pkg::*;

    localparam int PIPES       = 8;
    localparam int DEPTH       = 256;
    localparam int STALL_SPAN  = 400;
    localparam int CYCLE_LIMIT = 400000;

    // The two table copies: one steers stimulus planning, one predicts results.
    localparam int PLAN  = 0;
    localparam int TRACK = 1;

    // Opcodes that the block must reject.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic      send_valid = 1'b0;
    req_beat_t send_beat  = '0;
    logic      take_ready = 1'b0;

    mcpipe_req_if req_ch ();
    mcpipe_rsp_if rsp_ch ();

    assign req_ch.valid   = send_valid;
    assign req_ch.payload = send_beat;
    assign rsp_ch.ready   = take_ready;

    multi_channel_refcounted_pipe_fifo #(
        .PIPE_COUNT   (PIPES),
        .BUFFER_BYTES (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Behavioral pipe table, two copies.
    logic [7:0] ring_bytes [2][PIPES][DEPTH];
    logic [7:0] rd_ptr     [2][PIPES];
    logic [7:0] wr_ptr     [2][PIPES];
    logic [8:0] fill_level [2][PIPES];
    logic [7:0] reader_cnt [2][PIPES];
    logic [7:0] writer_cnt [2][PIPES];

    req_beat_t ops_to_send[$];
    rsp_beat_t pipe_results_due[$];

    int planned_ops    = 0;
    int mismatch_total = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_order    = 0;
    int stall_seen;
    int stall_left;

    function automatic bit pipe_live(int c, int p);
        return reader_cnt[c][p] != '0 || writer_cnt[c][p] != '0;
    endfunction

    function automatic logic [7:0] next_slot(logic [7:0] ptr);
        return (ptr == DEPTH - 1) ? 8'd0 : ptr + 8'd1;
    endfunction

    // Applies one request to table copy c and returns the response it causes.
    function automatic rsp_beat_t apply_pipe_op(int c, req_beat_t b);
        rsp_beat_t r;
        int        p;
        int        i;
        bit        granted;
        r           = '0;
        r.last_flag = b.last_byte;
        p           = b.pipe_index;
        granted     = 1'b1;
        if (b.opcode == OP_ALLOC)
        begin
            // Lowest-numbered free pipe wins.
            granted  = 1'b0;
            r.status = ST_NOFREE;
            for (i = 0; i < PIPES; i++)
            begin
                if (!granted && !pipe_live(c, i))
                begin
                    rd_ptr[c][i]     = '0;
                    wr_ptr[c][i]     = '0;
                    fill_level[c][i] = '0;
                    reader_cnt[c][i] = 8'd1;
                    writer_cnt[c][i] = 8'd1;
                    p                = i;
                    r.new_pipe       = 3'(i);
                    r.status         = ST_OK;
                    granted          = 1'b1;
                end
            end
        end
        else if (!pipe_live(c, p))
        begin
            r.status = ST_BAD;
        end
        else
        begin
            case (b.opcode)
                OP_WRITE:
                begin
                    if (writer_cnt[c][p] == '0)
                        r.status = ST_BAD;
                    else if (reader_cnt[c][p] == '0)
                        r.status = ST_EPIPE;
                    else if (fill_level[c][p] == DEPTH)
                        r.status = ST_BLOCK;
                    else
                    begin
                        ring_bytes[c][p][wr_ptr[c][p]] = b.data_in;
                        wr_ptr[c][p]     = next_slot(wr_ptr[c][p]);
                        fill_level[c][p] = fill_level[c][p] + 9'd1;
                    end
                end
                OP_READ:
                begin
                    if (reader_cnt[c][p] == '0)
                        r.status = ST_BAD;
                    else if (fill_level[c][p] != '0)
                    begin
                        r.data_out       = ring_bytes[c][p][rd_ptr[c][p]];
                        rd_ptr[c][p]     = next_slot(rd_ptr[c][p]);
                        fill_level[c][p] = fill_level[c][p] - 9'd1;
                    end
                    else
                        r.status = (writer_cnt[c][p] == '0) ? ST_EOF : ST_BLOCK;
                end
                OP_REF:
                begin
                    // Counts saturate at the top.
                    if (b.write_end && writer_cnt[c][p] != REF_MAX)
                        writer_cnt[c][p] = writer_cnt[c][p] + 8'd1;
                    else if (!b.write_end && reader_cnt[c][p] != REF_MAX)
                        reader_cnt[c][p] = reader_cnt[c][p] + 8'd1;
                end
                OP_CLOSE:
                begin
                    // Counts stop at zero.
                    if (b.write_end && writer_cnt[c][p] != '0)
                        writer_cnt[c][p] = writer_cnt[c][p] - 8'd1;
                    else if (!b.write_end && reader_cnt[c][p] != '0)
                        reader_cnt[c][p] = reader_cnt[c][p] - 8'd1;
                end
                default:
                begin
                    r.status = ST_BAD;
                end
            endcase
        end
        // Flags describe the addressed pipe after the operation.
        if (granted && pipe_live(c, p))
        begin
            r.readable = fill_level[c][p] != '0 || writer_cnt[c][p] == '0;
            r.writable = fill_level[c][p] != DEPTH || reader_cnt[c][p] == '0;
        end
        return r;
    endfunction

    // Queues one request and advances the planning copy of the table.
    function automatic rsp_beat_t queue_op(logic [2:0] op, int p, bit wend,
                                           logic [7:0] data, bit last);
        req_beat_t b;
        b.opcode     = op;
        b.pipe_index = 3'(p);
        b.write_end  = wend;
        b.data_in    = data;
        b.last_byte  = last;
        ops_to_send.push_back(b);
        planned_ops++;
        return apply_pipe_op(PLAN, b);
    endfunction

    function automatic int pick_live();
        int cand[$];
        int i;
        for (i = 0; i < PIPES; i++)
        begin
            if (pipe_live(PLAN, i))
                cand.push_back(i);
        end
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function automatic rsp_beat_t queue_alloc();
        return queue_op(OP_ALLOC, $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    // Burst of writes or reads with random data; the last beat is marked.
    task automatic queue_burst(logic [2:0] op, int p, int n);
        int k;
        for (k = 0; k < n; k++)
            void'(queue_op(op, p, 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)), k == n - 1));
    endtask

    // Drops references on both ends, then one more close on the pipe.
    task automatic release_pipe(int p);
        int k;
        int n;
        n = (reader_cnt[PLAN][p] > 12) ? 12 : reader_cnt[PLAN][p];
        for (k = 0; k < n; k++)
            void'(queue_op(OP_CLOSE, p, 1'b0, 8'($urandom_range(0, 255)), 1'b0));
        n = (writer_cnt[PLAN][p] > 12) ? 12 : writer_cnt[PLAN][p];
        for (k = 0; k < n; k++)
            void'(queue_op(OP_CLOSE, p, 1'b1, 8'($urandom_range(0, 255)), 1'b0));
        void'(queue_op(OP_CLOSE, p, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'b1));
    endtask

    // One random session step on a live pipe, or an allocation, or noise.
    task automatic random_session();
        int        p;
        int        r;
        int        live;
        int        i;
        req_beat_t junk;
        p    = pick_live();
        r    = $urandom_range(0, 99);
        live = 0;
        for (i = 0; i < PIPES; i++)
            live += pipe_live(PLAN, i);
        if (live >= 6 && r < 15)
            release_pipe(p);
        else if (p < 0 || r < 10 || (live < 3 && r < 25))
            void'(queue_alloc());
        else if (r < 40)
            queue_burst(OP_WRITE, p, $urandom_range(1, 10));
        else if (r < 68)
            queue_burst(OP_READ, p, $urandom_range(1, 10));
        else if (r < 76)
            void'(queue_op(OP_REF, p, 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        else if (r < 84)
            void'(queue_op(OP_CLOSE, p, 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        else if (r < 92)
            release_pipe(p);
        else
        begin
            // Noise: any field value, now and then an unused opcode.
            junk = req_beat_t'(16'($urandom));
            if ($urandom_range(0, 3) == 0)
                junk.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
                junk.opcode = 3'($urandom_range(OP_ALLOC, OP_CLOSE));
            void'(queue_op(junk.opcode, junk.pipe_index, junk.write_end,
                           junk.data_in, junk.last_byte));
        end
    endtask

    // Fills a fresh pipe past full, drains it past empty, then closes it.
    task automatic flood_pipe();
        rsp_beat_t got;
        int        p;
        got = queue_alloc();
        if (got.status == ST_OK)
        begin
            p = got.new_pipe;
            while (fill_level[PLAN][p] != DEPTH)
                queue_burst(OP_WRITE, p, 1);
            queue_burst(OP_WRITE, p, 2);
            while (fill_level[PLAN][p] != '0)
                queue_burst(OP_READ, p, 1);
            queue_burst(OP_READ, p, 1);
            void'(queue_op(OP_CLOSE, p, 1'b1, 8'h00, 1'b0));
            queue_burst(OP_READ, p, 1);
            void'(queue_op(OP_CLOSE, p, 1'b0, 8'h00, 1'b1));
        end
    endtask

    // Drives a writer count into saturation on a fresh pipe.
    task automatic saturate_writers();
        rsp_beat_t got;
        int        p;
        got = queue_alloc();
        if (got.status == ST_OK)
        begin
            p = got.new_pipe;
            repeat (257)
                void'(queue_op(OP_REF, p, 1'b1, 8'($urandom_range(0, 255)), 1'b0));
            void'(queue_op(OP_CLOSE, p, 1'b0, 8'h00, 1'b0));
            queue_burst(OP_WRITE, p, 2);
            queue_burst(OP_READ, p, 1);
        end
    endtask

    // Waits until every planned beat has been sent and answered.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (ops_to_send.size() != 0 || pipe_results_due.size() != 0 || send_valid);
    endtask

    // Request driver: predicts each accepted beat, then offers the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_beat  <= '0;
        end
        else
        begin
            if (send_valid && req_ch.ready)
                pipe_results_due.push_back(apply_pipe_op(TRACK, send_beat));
            if (!send_valid || req_ch.ready)
            begin
                if (ops_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    send_valid <= 1'b1;
                    send_beat  <= ops_to_send.pop_front();
                end
                else
                    send_valid <= 1'b0;
            end
        end
    end

    // Response monitor and receiver back-pressure, with a long stall on demand.
    always @(posedge clk)
    begin
        rsp_beat_t got;
        rsp_beat_t want;
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            stall_seen <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp_ch.valid && take_ready)
            begin
                got = rsp_ch.payload;
                if (pipe_results_due.size() == 0)
                begin
                    mismatch_total++;
                    $display("%0t: unexpected beat: status=%0d data=%02h pipe=%0d r=%b w=%b last=%b",
                             $time, got.status, got.data_out, got.new_pipe, got.readable,
                             got.writable, got.last_flag);
                end
                else
                begin
                    want = pipe_results_due.pop_front();
                    if (got.status !== want.status || got.data_out !== want.data_out ||
                        got.new_pipe !== want.new_pipe || got.readable !== want.readable ||
                        got.writable !== want.writable || got.last_flag !== want.last_flag)
                    begin
                        mismatch_total++;
                        $display("%0t: expected status=%0d data=%02h pipe=%0d r=%b w=%b last=%b",
                                 $time, want.status, want.data_out, want.new_pipe,
                                 want.readable, want.writable, want.last_flag);
                        $display("%0t:   actual status=%0d data=%02h pipe=%0d r=%b w=%b last=%b",
                                 $time, got.status, got.data_out, got.new_pipe,
                                 got.readable, got.writable, got.last_flag);
                    end
                end
            end
            if (stall_seen != stall_order)
            begin
                stall_seen <= stall_order;
                stall_left <= STALL_SPAN;
                take_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                take_ready <= 1'b0;
            end
            else
                take_ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // Watchdog.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timed out with %0d beats unsent, %0d results outstanding",
                 $time, ops_to_send.size(), pipe_results_due.size());
        $display("multi_channel_refcounted_pipe_fifo: mismatch");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int p = 0; p < PIPES; p++)
            begin
                rd_ptr[c][p]     = '0;
                wr_ptr[c][p]     = '0;
                fill_level[c][p] = '0;
                reader_cnt[c][p] = '0;
                writer_cnt[c][p] = '0;
            end
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: free pipes, data extremes, empty reads, closed ends, bad codes.
        void'(queue_op(OP_READ, 7, 1'b0, 8'h00, 1'b0));
        void'(queue_op(OP_CLOSE, 3, 1'b1, 8'hFF, 1'b1));
        void'(queue_op(OP_ALLOC, 5, 1'b1, 8'h00, 1'b0));
        void'(queue_op(OP_WRITE, 0, 1'b0, 8'hFF, 1'b0));
        void'(queue_op(OP_WRITE, 0, 1'b1, 8'h00, 1'b0));
        void'(queue_op(OP_WRITE, 0, 1'b0, 8'hA5, 1'b1));
        repeat (4)
            void'(queue_op(OP_READ, 0, 1'b0, 8'h00, 1'b0));
        void'(queue_op(OP_REF, 0, 1'b0, 8'h00, 1'b0));
        void'(queue_op(OP_REF, 0, 1'b1, 8'h00, 1'b0));
        repeat (3)
            void'(queue_op(OP_CLOSE, 0, 1'b1, 8'h00, 1'b0));
        void'(queue_op(OP_READ, 0, 1'b0, 8'h00, 1'b1));
        void'(queue_op(OP_WRITE, 0, 1'b1, 8'h5A, 1'b0));
        void'(queue_op(OP_ALLOC, 0, 1'b0, 8'h00, 1'b0));
        void'(queue_op(OP_CLOSE, 1, 1'b0, 8'h00, 1'b0));
        void'(queue_op(OP_WRITE, 1, 1'b0, 8'h3C, 1'b1));
        void'(queue_op(OP_UNUSED_LO, 0, 1'b1, 8'hFF, 1'b1));
        void'(queue_op(OP_UNUSED_HI, 7, 1'b0, 8'h00, 1'b0));
        repeat (2)
            void'(queue_op(OP_CLOSE, 0, 1'b0, 8'h00, 1'b0));
        void'(queue_op(OP_READ, 0, 1'b0, 8'h00, 1'b1));
        wait_drained();

        // Heavy receiver back-pressure.
        send_idle_pct = 27;
        recv_idle_pct = 77;
        flood_pipe();
        while (planned_ops < 650)
            random_session();
        wait_drained();

        // Long receiver stall with the sender pushing, so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_order   = stall_order + 1;
        repeat (6)
            random_session();
        wait_drained();

        // Heavy sender gaps.
        send_idle_pct = 77;
        recv_idle_pct = 27;
        repeat (PIPES + 1)
            void'(queue_alloc());
        while (planned_ops < 1250)
            random_session();
        wait_drained();

        // Full rate both ways.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        saturate_writers();
        while (planned_ops < 1850)
            random_session();
        wait_drained();

        repeat (16) @(posedge clk);
        if (mismatch_total == 0)
            $display("multi_channel_refcounted_pipe_fifo: match");
        else
            $display("multi_channel_refcounted_pipe_fifo: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
